FILE: design/wsd_pkg.sv
package wsd_pkg;

	localparam int CAPACITY    = 256;
	localparam int HANDLE_BITS = 32;
	localparam int SLOT_W      = $clog2(CAPACITY);
	localparam int IDX_W       = SLOT_W + 1;
	localparam int WORD_BITS   = 32;
	localparam int RQ_DEPTH    = 4;
	localparam int RQ_PTR_W    = $clog2(RQ_DEPTH);
	localparam int RQ_LVL_W    = RQ_PTR_W + 1;

	typedef logic [HANDLE_BITS-1:0] handle_t;
	typedef logic [WORD_BITS-1:0]   word_t;
	typedef logic [SLOT_W-1:0]      slot_t;
	typedef logic [IDX_W-1:0]       idx_t;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_STEAL = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// control handed from the front stage to the result queue
	typedef struct packed {
		logic    valid;
		status_t status;
		logic    rd;
	} front_to_back_t;

	typedef struct packed {
		status_t status;
		word_t   hnd;
	} result_t;

	function automatic handle_t to_slot(input word_t w);
		to_slot = handle_t'(w);
	endfunction

	function automatic word_t from_slot(input handle_t h);
		from_slot = word_t'(h);
	endfunction

endpackage

FILE: design/wsd_ram.sv
module wsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/wsd_front.sv
module wsd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              req_type,
	input  wsd_pkg::word_t          task_handle,
	input  logic                    room,
	output logic                    ram_we,
	output wsd_pkg::slot_t          ram_waddr,
	output wsd_pkg::handle_t        ram_wdata,
	output logic                    ram_re,
	output wsd_pkg::slot_t          ram_raddr,
	output wsd_pkg::front_to_back_t fb
);

	wsd_pkg::idx_t          top_q, bottom_q;
	wsd_pkg::idx_t          top_d, bottom_d;
	wsd_pkg::idx_t          count, bm1;
	logic                   accept;
	logic                   full, empty;
	logic                   rd;
	wsd_pkg::status_t       status;
	wsd_pkg::front_to_back_t fb_s1;

	assign accept   = in_valid & room;
	assign in_stall = ~room;
	assign count    = bottom_q - top_q;
	assign bm1      = bottom_q - wsd_pkg::idx_t'(1);
	assign full     = (count == wsd_pkg::idx_t'(wsd_pkg::CAPACITY));
	assign empty    = (count == '0);

	// classify the request and plan the index moves
	always_comb begin
		top_d     = top_q;
		bottom_d  = bottom_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = bottom_q[wsd_pkg::SLOT_W-1:0];
		ram_raddr = top_q[wsd_pkg::SLOT_W-1:0];
		ram_wdata = wsd_pkg::to_slot(task_handle);
		rd        = 1'b0;
		status    = wsd_pkg::ST_EMPTY;
		unique case (req_type)
			wsd_pkg::REQ_PUSH: begin
				if (full) begin
					status = wsd_pkg::ST_FULL;
				end else begin
					status   = wsd_pkg::ST_OK;
					ram_we   = accept;
					bottom_d = bottom_q + wsd_pkg::idx_t'(1);
				end
			end
			wsd_pkg::REQ_POP: begin
				if (!empty) begin
					status    = wsd_pkg::ST_OK;
					rd        = 1'b1;
					ram_re    = accept;
					ram_raddr = bm1[wsd_pkg::SLOT_W-1:0];
					// last element goes by the top, bottom stays
					if (count == wsd_pkg::idx_t'(1)) begin
						top_d = top_q + wsd_pkg::idx_t'(1);
					end else begin
						bottom_d = bm1;
					end
				end
			end
			wsd_pkg::REQ_STEAL: begin
				if (!empty) begin
					status = wsd_pkg::ST_OK;
					rd     = 1'b1;
					ram_re = accept;
					top_d  = top_q + wsd_pkg::idx_t'(1);
				end
			end
			default: begin
				status = wsd_pkg::ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			bottom_q <= '0;
			fb_s1    <= '0;
		end else begin
			fb_s1.valid <= accept;
			if (accept) begin
				top_q        <= top_d;
				bottom_q     <= bottom_d;
				fb_s1.status <= status;
				fb_s1.rd     <= rd;
			end
		end
	end

	assign fb = fb_s1;

endmodule

FILE: design/wsd_back.sv
module wsd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wsd_pkg::front_to_back_t fb,
	input  wsd_pkg::handle_t        ram_rdata,
	output logic                    room,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output wsd_pkg::word_t          task_out
);

	wsd_pkg::result_t                entry_q [wsd_pkg::RQ_DEPTH];
	logic [wsd_pkg::RQ_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [wsd_pkg::RQ_LVL_W-1:0]    level_q;
	logic [wsd_pkg::RQ_LVL_W-1:0]    pending;
	logic                            deq;
	wsd_pkg::result_t                head;

	// count the word still in the front stage so it always finds a place
	assign pending   = level_q + wsd_pkg::RQ_LVL_W'(fb.valid);
	assign room      = (pending < wsd_pkg::RQ_LVL_W'(wsd_pkg::RQ_DEPTH));
	assign out_valid = (level_q != '0);
	assign deq       = out_valid & ~out_stall;
	assign head      = entry_q[rd_ptr_q];
	assign status    = head.status;
	assign task_out  = head.hnd;

	always_ff @(posedge clk) begin
		if (fb.valid) begin
			entry_q[wr_ptr_q].status <= fb.status;
			entry_q[wr_ptr_q].hnd    <= fb.rd ? wsd_pkg::from_slot(ram_rdata) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (fb.valid) begin
				wr_ptr_q <= wr_ptr_q + wsd_pkg::RQ_PTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + wsd_pkg::RQ_PTR_W'(1);
			end
			level_q <= level_q + wsd_pkg::RQ_LVL_W'(fb.valid)
				- wsd_pkg::RQ_LVL_W'(deq);
		end
	end

endmodule

FILE: design/work_stealing_deque.sv
// Work-stealing deque: a ring of CAPACITY task handles between a top and a
// bottom index. Each input word is one request (push or pop at the bottom,
// steal at the top) and yields exactly one result word carrying a status
// (success, full or empty) and, for a successful pop or steal, the handle.
// The block takes one request per cycle while in_stall is low; each result
// passes the front-stage register and the result queue. The front stage
// owns both indices, so every request is classified and its index update
// done in the cycle it is accepted; that index update and the one write /
// one registered read port of the slot RAM set the rate. Results then sit
// in a four-word queue, and the input stalls only while that queue plus
// the word in flight would fill it. Slots hold no reset value; only slots
// written by a push are ever read.
module work_stealing_deque (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic [31:0]         task_handle,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [31:0]         task_out
);

	logic                    room;
	logic                    ram_we, ram_re;
	wsd_pkg::slot_t          ram_waddr, ram_raddr;
	wsd_pkg::handle_t        ram_wdata, ram_rdata;
	wsd_pkg::front_to_back_t fb;

	// front: accept, classify, move indices, issue the slot access
	wsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.task_handle (task_handle),
		.room        (room),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.fb          (fb)
	);

	// slot ring
	wsd_ram #(
		.WIDTH (wsd_pkg::HANDLE_BITS),
		.DEPTH (wsd_pkg::CAPACITY)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// back: capture read data, hold results until taken
	wsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fb        (fb),
		.ram_rdata (ram_rdata),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.task_out  (task_out)
	);

endmodule

FILE: design/wsd_checker.sv
module wsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  req_type,
	input logic [31:0] task_handle,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] task_out
);

	logic [7:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid & ~in_stall;
	assign out_acc = out_valid & ~out_stall;

	// track words accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 8'(in_acc) - 8'(out_acc);
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result word without a pending request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == wsd_pkg::ST_OK || status == wsd_pkg::ST_FULL
			|| status == wsd_pkg::ST_EMPTY))
		else $error("undefined status code");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != wsd_pkg::ST_OK |-> task_out == '0)
		else $error("refused or empty result carries a handle");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(task_out))
		else $error("stalled result word changed");

endmodule

bind work_stealing_deque wsd_checker u_wsd_checker (.*);
